/* src/clipped_line_run_rasterizer_core_defines.svh */
// Assertion macros shared by the rasterizer modules.
// Each module that asserts includes this file; clk and rst are taken from the including scope.
`ifndef CLIPPED_LINE_RUN_RASTERIZER_CORE_DEFINES_SVH
`define CLIPPED_LINE_RUN_RASTERIZER_CORE_DEFINES_SVH

// same-cycle implication
`define CLRR_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("clrr assertion failed");

// next-cycle implication
`define CLRR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("clrr assertion failed");

`endif

/* src/clrr_pkg.sv */
// Package for the clipped line run rasterizer: codes, defaults and shared types.
// No dependencies.
`timescale 1ns / 1ps

package clrr_pkg;

  localparam int CoordWidthDefault = 9;
  localparam int QueueDepth        = 2;

  // window reset values
  localparam int WinLeftReset   = 0;
  localparam int WinTopReset    = 0;
  localparam int WinRightReset  = 319;
  localparam int WinBottomReset = 239;

  // config register indexes
  localparam logic [1:0] REG_WIN_LEFT   = 2'd0;
  localparam logic [1:0] REG_WIN_TOP    = 2'd1;
  localparam logic [1:0] REG_WIN_RIGHT  = 2'd2;
  localparam logic [1:0] REG_WIN_BOTTOM = 2'd3;

  // input function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  // classification of a queued item
  typedef struct packed {
    logic is_load;
    logic straight;
    logic steep;
  } cmd_flags_t;

  localparam int FlagsWidth = $bits(cmd_flags_t);

endpackage

/* src/clipped_line_run_rasterizer_core.sv */
// Clipped line run rasterizer. Load item: taken in ST_IDLE, no result. Step item (line
// active): ST_RUN walks the run (skipped for a straight line), then ST_EMIT loads the result
// register once the output is free; the error-term walk covers one pixel per cycle. A 2-entry
// queue decouples input; the back end takes the next item only from ST_IDLE.
// Reset: window 0,0,319,239, no line active, queue and output empty; no clearing pass.
`timescale 1ns / 1ps

module clipped_line_run_rasterizer_core import clrr_pkg::*; #(
  parameter int COORD_WIDTH = CoordWidthDefault
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   func,
  input  logic [COORD_WIDTH-1:0] x_start,
  input  logic [COORD_WIDTH-1:0] y_start,
  input  logic [COORD_WIDTH-1:0] x_end,
  input  logic [COORD_WIDTH-1:0] y_end,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COORD_WIDTH:0]   rect_x,
  output logic [COORD_WIDTH:0]   rect_y,
  output logic [COORD_WIDTH:0]   rect_w,
  output logic [COORD_WIDTH:0]   rect_h,
  output logic                   drawn,
  output logic                   last,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [COORD_WIDTH-1:0] cfg_data
);

  localparam int CW = COORD_WIDTH;
  localparam int QW = FlagsWidth + 4 * CW;

  logic [CW-1:0] win_left, win_top, win_right, win_bottom;

  logic          push, pop, q_full, q_empty;
  cmd_flags_t    f_flags, b_flags;
  logic [CW-1:0] f_maj_lo, f_maj_hi, f_min_lo, f_min_hi;
  logic [CW-1:0] b_maj_lo, b_maj_hi, b_min_lo, b_min_hi;
  logic [QW-1:0] q_din, q_dout;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_left   <= CW'(WinLeftReset);
      win_top    <= CW'(WinTopReset);
      win_right  <= CW'(WinRightReset);
      win_bottom <= CW'(WinBottomReset);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIN_LEFT:   win_left   <= cfg_data;
        REG_WIN_TOP:    win_top    <= cfg_data;
        REG_WIN_RIGHT:  win_right  <= cfg_data;
        REG_WIN_BOTTOM: win_bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  clrr_front #(.COORD_WIDTH(CW)) u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .x_start  (x_start),
    .y_start  (y_start),
    .x_end    (x_end),
    .y_end    (y_end),
    .q_full   (q_full),
    .push     (push),
    .flags    (f_flags),
    .maj_lo   (f_maj_lo),
    .maj_hi   (f_maj_hi),
    .min_lo   (f_min_lo),
    .min_hi   (f_min_hi)
  );

  assign q_din = {f_flags, f_maj_lo, f_maj_hi, f_min_lo, f_min_hi};
  assign {b_flags, b_maj_lo, b_maj_hi, b_min_lo, b_min_hi} = q_dout;

  clrr_queue #(.WIDTH(QW)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (q_din),
    .pop   (pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  clrr_back #(.COORD_WIDTH(CW)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .pop        (pop),
    .flags      (b_flags),
    .maj_lo     (b_maj_lo),
    .maj_hi     (b_maj_hi),
    .min_lo     (b_min_lo),
    .min_hi     (b_min_hi),
    .win_left   (win_left),
    .win_top    (win_top),
    .win_right  (win_right),
    .win_bottom (win_bottom),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .rect_x     (rect_x),
    .rect_y     (rect_y),
    .rect_w     (rect_w),
    .rect_h     (rect_h),
    .drawn      (drawn),
    .last       (last)
  );

endmodule

/* src/clrr_front.sv */
// Front end: accepts items and classifies line loads (straight/steep, endpoint order).
// Depends on clrr_pkg.
`timescale 1ns / 1ps

module clrr_front import clrr_pkg::*; #(
  parameter int COORD_WIDTH = CoordWidthDefault
) (
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   func,
  input  logic [COORD_WIDTH-1:0] x_start,
  input  logic [COORD_WIDTH-1:0] y_start,
  input  logic [COORD_WIDTH-1:0] x_end,
  input  logic [COORD_WIDTH-1:0] y_end,
  input  logic                   q_full,
  output logic                   push,
  output cmd_flags_t             flags,
  output logic [COORD_WIDTH-1:0] maj_lo,
  output logic [COORD_WIDTH-1:0] maj_hi,
  output logic [COORD_WIDTH-1:0] min_lo,
  output logic [COORD_WIDTH-1:0] min_hi
);

  logic                   vert, horiz, steep, swap;
  logic [COORD_WIDTH-1:0] adx, ady, ma, mb, na, nb;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    vert  = (x_start == x_end);
    horiz = (y_start == y_end);
    adx   = (x_start > x_end) ? x_start - x_end : x_end - x_start;
    ady   = (y_start > y_end) ? y_start - y_end : y_end - y_start;
    // vertical test wins for straight lines
    steep = (vert || horiz) ? vert : (ady > adx);
    ma    = steep ? y_start : x_start;
    na    = steep ? x_start : y_start;
    mb    = steep ? y_end   : x_end;
    nb    = steep ? x_end   : y_end;
    swap  = (ma > mb);
    maj_lo = swap ? mb : ma;
    maj_hi = swap ? ma : mb;
    min_lo = swap ? nb : na;
    min_hi = swap ? na : nb;
    flags.is_load  = (func == FUNC_LOAD);
    flags.straight = vert || horiz;
    flags.steep    = steep;
  end

endmodule

/* src/clrr_queue.sv */
// Short item queue between the front and back ends.
// Depends on clrr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "clipped_line_run_rasterizer_core_defines.svh"

module clrr_queue import clrr_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  logic [WIDTH-1:0] entries [QueueDepth];
  logic [PtrW-1:0]  wr_ptr, rd_ptr;
  logic [CntW-1:0]  count;

  assign full  = (count == CntW'(QueueDepth));
  assign empty = (count == '0);
  assign dout  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `CLRR_ASSERT(fill_bounded, 1'b1, count <= CntW'(QueueDepth))
  `CLRR_ASSERT(no_pop_when_empty, pop, !empty)
  `CLRR_ASSERT_NEXT(count_tracks_push, push && !pop, count == $past(count) + 1'b1)

endmodule

/* src/clrr_back.sv */
// Back end: line state, Bresenham run walk, window clip and output register.
// Depends on clrr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "clipped_line_run_rasterizer_core_defines.svh"

module clrr_back import clrr_pkg::*; #(
  parameter int COORD_WIDTH = CoordWidthDefault
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_empty,
  output logic                   pop,
  input  cmd_flags_t             flags,
  input  logic [COORD_WIDTH-1:0] maj_lo,
  input  logic [COORD_WIDTH-1:0] maj_hi,
  input  logic [COORD_WIDTH-1:0] min_lo,
  input  logic [COORD_WIDTH-1:0] min_hi,
  input  logic [COORD_WIDTH-1:0] win_left,
  input  logic [COORD_WIDTH-1:0] win_top,
  input  logic [COORD_WIDTH-1:0] win_right,
  input  logic [COORD_WIDTH-1:0] win_bottom,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COORD_WIDTH:0]   rect_x,
  output logic [COORD_WIDTH:0]   rect_y,
  output logic [COORD_WIDTH:0]   rect_w,
  output logic [COORD_WIDTH:0]   rect_h,
  output logic                   drawn,
  output logic                   last
);

  localparam int CW = COORD_WIDTH;
  localparam int EW = COORD_WIDTH + 2;
  localparam logic [CW:0] One = (CW+1)'(1);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_EMIT} state_t;

  state_t state;

  logic                 line_active, steep_mode, straight_mode, minor_up;
  logic                 run_last, stepped;
  logic [CW:0]          major_pos, run_len;
  logic [CW-1:0]        major_limit, minor_pos, delta_major, delta_minor, run_begin;
  logic signed [EW-1:0] error_term;

  // load decode
  logic [CW-1:0] dmaj_new, dmin_new;
  // run step
  logic signed [EW-1:0] err_sub, err_add;
  logic [CW:0]          mp_inc;
  logic                 past_end;
  // clip
  logic [CW-1:0] rx, ry;
  logic [CW:0]   rw, rh, ax, ay, cap_w, cap_h, cw_clip, ch_clip;
  logic          in_win, vis, emit_fire;

  assign pop       = (state == ST_IDLE) && !q_empty;
  assign emit_fire = (state == ST_EMIT) && (!out_valid || out_ready);

  always_comb begin
    dmaj_new = maj_hi - maj_lo;
    dmin_new = (min_hi >= min_lo) ? min_hi - min_lo : min_lo - min_hi;

    err_sub  = error_term - $signed({2'b00, delta_minor});
    err_add  = err_sub + $signed({2'b00, delta_major});
    mp_inc   = major_pos + 1'b1;
    past_end = (mp_inc > {1'b0, major_limit});

    rx = steep_mode ? minor_pos : run_begin;
    ry = steep_mode ? run_begin : minor_pos;
    rw = steep_mode ? One : run_len;
    rh = steep_mode ? run_len : One;
    ax = {1'b0, win_left} + {1'b0, rx};
    ay = {1'b0, win_top} + {1'b0, ry};
    in_win  = (ax <= {1'b0, win_right}) && (ay <= {1'b0, win_bottom});
    cap_w   = {1'b0, win_right} + One - ax;
    cap_h   = {1'b0, win_bottom} + One - ay;
    cw_clip = (rw > cap_w) ? cap_w : rw;
    ch_clip = (rh > cap_h) ? cap_h : rh;
    vis     = in_win && (cw_clip != '0) && (ch_clip != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      line_active <= 1'b0;
    end else begin
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            if (flags.is_load) begin
              line_active   <= 1'b1;
              straight_mode <= flags.straight;
              steep_mode    <= flags.steep;
              major_pos     <= {1'b0, maj_lo};
              major_limit   <= maj_hi;
              minor_pos     <= min_lo;
              minor_up      <= (min_lo < min_hi);
              delta_major   <= dmaj_new;
              delta_minor   <= dmin_new;
              error_term    <= $signed({3'b000, dmaj_new[CW-1:1]});
            end else if (line_active) begin
              run_begin <= major_pos[CW-1:0];
              stepped   <= 1'b0;
              if (straight_mode) begin
                // end-exclusive single rectangle
                run_len  <= {1'b0, major_limit - major_pos[CW-1:0]};
                run_last <= 1'b1;
                state    <= ST_EMIT;
              end else begin
                run_len <= '0;
                state   <= ST_RUN;
              end
            end
          end
        end
        ST_RUN: begin
          run_len   <= run_len + 1'b1;
          major_pos <= mp_inc;
          if (err_sub < 0) begin
            error_term <= err_add;
            stepped    <= 1'b1;
            run_last   <= past_end;
            state      <= ST_EMIT;
          end else begin
            error_term <= err_sub;
            if (past_end) begin
              run_last <= 1'b1;
              state    <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (emit_fire) begin
            rect_x <= ax;
            rect_y <= ay;
            rect_w <= vis ? cw_clip : '0;
            rect_h <= vis ? ch_clip : '0;
            drawn  <= vis;
            last   <= run_last;
            if (stepped) begin
              minor_pos <= minor_up ? minor_pos + 1'b1 : minor_pos - 1'b1;
            end
            if (run_last) begin
              line_active <= 1'b0;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `CLRR_ASSERT(run_needs_sloped_line, state == ST_RUN, line_active && !straight_mode)
  `CLRR_ASSERT(dropped_run_is_empty, out_valid && !drawn, rect_w == '0 && rect_h == '0)
  `CLRR_ASSERT(sloped_run_not_empty, state == ST_EMIT && !straight_mode, run_len != '0)

endmodule
